FILE: hw/rtl/fgra_pkg.sv
// Shared types, constants and the arctangent table of the field-relative gimbal angle block.
package fgra_pkg;

  localparam int ANGLE_W = 16;
  localparam int XW      = 21;   // CORDIC x/y datapath width
  localparam int ZW      = 26;   // CORDIC angle accumulator width, 2^23 per pi
  localparam int ATAN_W  = 22;
  localparam int MAX_STEPS = 24;
  localparam logic signed [15:0] GAIN_Q15 = 16'sd19898;

  typedef enum logic [1:0] {
    REG_YAW_OFFSET   = 2'd0,
    REG_PITCH_OFFSET = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] gimbal_yaw;
    logic signed [ANGLE_W-1:0] gimbal_pitch;
    logic signed [ANGLE_W-1:0] chassis_yaw;
    logic signed [ANGLE_W-1:0] chassis_pitch;
    logic signed [ANGLE_W-1:0] chassis_roll;
  } sample_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] field_yaw;
    logic signed [ANGLE_W-1:0] field_pitch;
    logic signed [ANGLE_W-1:0] tilt_along_heading;
  } angles_t;

  // atan(2^-i) in accumulator units, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_entry(input int unsigned i);
    logic [ATAN_W-1:0] a;
    case (i)
      0:  a = 22'd2097152;
      1:  a = 22'd1238021;
      2:  a = 22'd654136;
      3:  a = 22'd332050;
      4:  a = 22'd166669;
      5:  a = 22'd83416;
      6:  a = 22'd41718;
      7:  a = 22'd20860;
      8:  a = 22'd10430;
      9:  a = 22'd5215;
      10: a = 22'd2608;
      11: a = 22'd1304;
      12: a = 22'd652;
      13: a = 22'd326;
      14: a = 22'd163;
      15: a = 22'd81;
      16: a = 22'd41;
      17: a = 22'd20;
      18: a = 22'd10;
      19: a = 22'd5;
      20: a = 22'd3;
      21: a = 22'd1;
      22: a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: hw/rtl/fgra_cordic_step.sv
// One registered CORDIC micro-rotation, rotation or vectoring mode.
module fgra_cordic_step #(
  parameter int STEP   = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [fgra_pkg::XW-1:0] x_in,
  input  logic signed [fgra_pkg::XW-1:0] y_in,
  input  logic signed [fgra_pkg::ZW-1:0] z_in,
  output logic signed [fgra_pkg::XW-1:0] x_out,
  output logic signed [fgra_pkg::XW-1:0] y_out,
  output logic signed [fgra_pkg::ZW-1:0] z_out
);

  logic signed [fgra_pkg::XW-1:0] dx;
  logic signed [fgra_pkg::XW-1:0] dy;
  logic signed [fgra_pkg::ZW-1:0] a;
  logic                           up;
  logic signed [fgra_pkg::XW-1:0] x_next;
  logic signed [fgra_pkg::XW-1:0] y_next;
  logic signed [fgra_pkg::ZW-1:0] z_next;

  always_comb begin
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
    a  = signed'({{(fgra_pkg::ZW-fgra_pkg::ATAN_W){1'b0}},
                  fgra_pkg::atan_entry(STEP)});
    // rotation drives z to zero, vectoring drives y to zero
    up = VECTOR ? ~y_in[fgra_pkg::XW-1] : ~z_in[fgra_pkg::ZW-1];
    if (VECTOR) begin
      x_next = up ? x_in + dx : x_in - dx;
      y_next = up ? y_in - dy : y_in + dy;
      z_next = up ? z_in + a  : z_in - a;
    end else begin
      x_next = up ? x_in - dx : x_in + dx;
      y_next = up ? y_in + dy : y_in - dy;
      z_next = up ? z_in - a  : z_in + a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_next;
      y_out <= y_next;
      z_out <= z_next;
    end
  end

endmodule

FILE: hw/rtl/field_relative_gimbal_angles.sv
// Top level: pipelined field-relative gimbal yaw and pitch with tilt projection.
//
//  channel  | valid         | stall         | payload           | width
//  ---------+---------------+---------------+-------------------+------
//  sample   | sample_valid  | sample_stall  | sample (sample_t) | 80
//  angles   | angles_valid  | angles_stall  | angles (angles_t) | 48
//  config   | cfg_write     | -             | cfg_index/cfg_data| 2/16
//
// One transaction enters every cycle unless sample_stall is high. The
// pipeline stages, N being CORDIC_STEPS capped at 24, are an input register,
// N sine/cosine steps, negate, multiply, sum, N root steps, gain multiply,
// N atan2 steps and the output register. The whole pipeline advances
// together; a stalled result at the output holds every stage and raises
// sample_stall. Reset clears valid bits and the offset registers only.
module field_relative_gimbal_angles #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  fgra_pkg::sample_t        sample,
  output logic                     angles_valid,
  input  logic                     angles_stall,
  output fgra_pkg::angles_t        angles,
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  localparam int N  = (CORDIC_STEPS > fgra_pkg::MAX_STEPS) ? fgra_pkg::MAX_STEPS
                                                            : CORDIC_STEPS;
  localparam int XW = fgra_pkg::XW;
  localparam int ZW = fgra_pkg::ZW;

  // sideband carried alongside the arithmetic
  typedef struct packed {
    logic signed [15:0] gy;
    logic signed [15:0] gp;
    logic signed [15:0] cy;
    logic [2:0]         neg;
    logic signed [17:0] num;
    logic               zero;
  } side_t;

  function automatic logic signed [15:0] sat16(input logic signed [XW-1:0] v);
    logic signed [15:0] r;
    if (v > XW'(32767))       r = 16'sh7fff;
    else if (v < -XW'(32768)) r = 16'sh8000;
    else                      r = v[15:0];
    return r;
  endfunction

  logic               en;
  logic signed [15:0] yaw_offset;
  logic signed [15:0] pitch_offset;

  // advance everything unless the output holds a result nobody takes
  assign en           = ~(angles_valid & angles_stall);
  assign sample_stall = ~en;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_offset   <= '0;
      pitch_offset <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        fgra_pkg::REG_YAW_OFFSET:   yaw_offset   <= cfg_data;
        fgra_pkg::REG_PITCH_OFFSET: pitch_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic              s0_vld;
  fgra_pkg::sample_t s0;

  always_ff @(posedge clk) begin
    if (rst) s0_vld <= 1'b0;
    else if (en) s0_vld <= sample_valid;
    if (en) s0 <= sample;
  end

  // sine/cosine: fold into [-pi/2, pi/2], rotate, negate back
  logic signed [XW-1:0] rx [3][N+1];
  logic signed [XW-1:0] ry [3][N+1];
  logic signed [ZW-1:0] rz [3][N+1];
  side_t                rs [N+1];
  logic                 rv [N+1];
  logic signed [15:0]   ang [3];
  logic [2:0]           fold_neg;
  logic signed [16:0]   folded [3];

  always_comb begin
    ang[0] = s0.gimbal_yaw;
    ang[1] = s0.chassis_pitch;
    ang[2] = s0.chassis_roll;
    for (int j = 0; j < 3; j++) begin
      if (ang[j] > 16'sd16384) begin
        folded[j]   = 17'(ang[j]) - 17'sd32768;
        fold_neg[j] = 1'b1;
      end else if (ang[j] < -16'sd16384) begin
        folded[j]   = 17'(ang[j]) + 17'sd32768;
        fold_neg[j] = 1'b1;
      end else begin
        folded[j]   = 17'(ang[j]);
        fold_neg[j] = 1'b0;
      end
    end
    rs[0].gy   = s0.gimbal_yaw;
    rs[0].gp   = s0.gimbal_pitch;
    rs[0].cy   = s0.chassis_yaw;
    rs[0].neg  = fold_neg;
    rs[0].num  = '0;
    rs[0].zero = 1'b0;
    rv[0]      = s0_vld;
  end

  // seed each rotation with the gain-compensated unit vector
  for (genvar j = 0; j < 3; j++) begin : g_seed
    assign rx[j][0] = XW'(fgra_pkg::GAIN_Q15);
    assign ry[j][0] = '0;
    assign rz[j][0] = ZW'(folded[j]) <<< 8;
  end

  for (genvar k = 0; k < N; k++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) rv[k+1] <= 1'b0;
      else if (en) rv[k+1] <= rv[k];
      if (en) rs[k+1] <= rs[k];
    end
    for (genvar j = 0; j < 3; j++) begin : g_ang
      fgra_cordic_step #(.STEP(k), .VECTOR(1'b0)) u_step (
        .clk  (clk),
        .en   (en),
        .x_in (rx[j][k]),
        .y_in (ry[j][k]),
        .z_in (rz[j][k]),
        .x_out(rx[j][k+1]),
        .y_out(ry[j][k+1]),
        .z_out(rz[j][k+1])
      );
    end
  end

  // negate folded results and saturate to Q1.15
  logic               p_vld;
  side_t              p_side;
  logic signed [15:0] p_sin [3];
  logic signed [15:0] p_cos [3];

  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else if (en) p_vld <= rv[N];
    if (en) begin
      p_side <= rs[N];
      for (int j = 0; j < 3; j++) begin
        p_cos[j] <= sat16(rs[N].neg[j] ? -rx[j][N] : rx[j][N]);
        p_sin[j] <= sat16(rs[N].neg[j] ? -ry[j][N] : ry[j][N]);
      end
    end
  end

  // products in Q2.30
  logic               m_vld;
  side_t              m_side;
  logic signed [31:0] m_prod [4];

  always_ff @(posedge clk) begin
    if (rst) m_vld <= 1'b0;
    else if (en) m_vld <= p_vld;
    if (en) begin
      m_side    <= p_side;
      m_prod[0] <= p_cos[0] * p_sin[1];
      m_prod[1] <= p_sin[0] * p_sin[2];
      m_prod[2] <= p_sin[0] * p_cos[2];
      m_prod[3] <= p_cos[0] * p_cos[1];
    end
  end

  // numerator and root operands
  logic               s_vld;
  side_t              s_side;
  logic signed [17:0] s_p1;
  logic signed [17:0] s_p2;
  logic signed [32:0] num_sum;
  logic signed [16:0] q1;
  logic signed [16:0] q2;
  side_t              s_side_next;

  always_comb begin
    num_sum         = 33'(m_prod[0]) + 33'(m_prod[1]);
    q1              = 17'(m_prod[2] >>> 15);
    q2              = 17'(m_prod[3] >>> 15);
    s_side_next     = m_side;
    s_side_next.num = 18'(num_sum >>> 15);
  end

  always_ff @(posedge clk) begin
    if (rst) s_vld <= 1'b0;
    else if (en) s_vld <= m_vld;
    if (en) begin
      s_side <= s_side_next;
      s_p1   <= q1[16] ? -18'(q1) : 18'(q1);
      s_p2   <= q2[16] ? -18'(q2) : 18'(q2);
    end
  end

  // vectoring CORDIC for the root
  logic signed [XW-1:0] ax [N+1];
  logic signed [XW-1:0] ay [N+1];
  logic signed [ZW-1:0] az [N+1];
  side_t                as_ [N+1];
  logic                 av [N+1];

  assign ax[0]  = XW'(s_p2);
  assign ay[0]  = XW'(s_p1);
  assign az[0]  = '0;
  assign as_[0] = s_side;
  assign av[0]  = s_vld;

  for (genvar k = 0; k < N; k++) begin : g_root
    always_ff @(posedge clk) begin
      if (rst) av[k+1] <= 1'b0;
      else if (en) av[k+1] <= av[k];
      if (en) as_[k+1] <= as_[k];
    end
    fgra_cordic_step #(.STEP(k), .VECTOR(1'b1)) u_step (
      .clk  (clk),
      .en   (en),
      .x_in (ax[k]),
      .y_in (ay[k]),
      .z_in (az[k]),
      .x_out(ax[k+1]),
      .y_out(ay[k+1]),
      .z_out(az[k+1])
    );
  end

  // remove the CORDIC gain from the root; flag the degenerate atan2
  logic                      q_vld;
  side_t                     q_side;
  logic signed [XW-1:0]      q_root;
  logic signed [XW+15:0]     root_prod;
  logic signed [XW-1:0]      root_next;
  side_t                     q_side_next;

  always_comb begin
    root_prod        = ax[N] * (XW+16)'(fgra_pkg::GAIN_Q15);
    root_next        = XW'(root_prod >>> 15);
    q_side_next      = as_[N];
    q_side_next.zero = (root_next == '0) && (as_[N].num == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) q_vld <= 1'b0;
    else if (en) q_vld <= av[N];
    if (en) begin
      q_side <= q_side_next;
      q_root <= root_next;
    end
  end

  // atan2 vectoring CORDIC
  logic signed [XW-1:0] tx [N+1];
  logic signed [XW-1:0] ty [N+1];
  logic signed [ZW-1:0] tz [N+1];
  side_t                ts [N+1];
  logic                 tv [N+1];

  assign tx[0] = q_root;
  assign ty[0] = XW'(q_side.num);
  assign tz[0] = '0;
  assign ts[0] = q_side;
  assign tv[0] = q_vld;

  for (genvar k = 0; k < N; k++) begin : g_atan
    always_ff @(posedge clk) begin
      if (rst) tv[k+1] <= 1'b0;
      else if (en) tv[k+1] <= tv[k];
      if (en) ts[k+1] <= ts[k];
    end
    fgra_cordic_step #(.STEP(k), .VECTOR(1'b1)) u_step (
      .clk  (clk),
      .en   (en),
      .x_in (tx[k]),
      .y_in (ty[k]),
      .z_in (tz[k]),
      .x_out(tx[k+1]),
      .y_out(ty[k+1]),
      .z_out(tz[k+1])
    );
  end

  // round to binary angle, clamp to +-pi/2, apply offsets with wrap
  logic signed [ZW-1:0] z_round;
  logic signed [17:0]   t_bam;
  logic signed [15:0]   tilt;
  fgra_pkg::angles_t    angles_next;

  always_comb begin
    z_round = (tz[N] + ZW'(128)) >>> 8;
    t_bam   = 18'(z_round);
    if (ts[N].zero)                t_bam = '0;
    else if (t_bam > 18'sd16384)   t_bam = 18'sd16384;
    else if (t_bam < -18'sd16384)  t_bam = -18'sd16384;
    tilt                           = t_bam[15:0];
    angles_next.field_yaw          = ts[N].gy + ts[N].cy - yaw_offset;
    angles_next.field_pitch        = ts[N].gp + tilt - pitch_offset;
    angles_next.tilt_along_heading = tilt;
  end

  always_ff @(posedge clk) begin
    if (rst) angles_valid <= 1'b0;
    else if (en) angles_valid <= tv[N];
    if (en) angles <= angles_next;
  end

  a_tilt_range: assert property (@(posedge clk) disable iff (rst)
    angles_valid |-> (angles.tilt_along_heading <= 16'sd16384) &&
                     (angles.tilt_along_heading >= -16'sd16384))
    else $error("tilt outside +-pi/2");

  a_root_held: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(q_root) && $stable(q_vld))
    else $error("root stage moved during a stall");

  a_rot_advance: assert property (@(posedge clk) disable iff (rst)
    (rv[N] && en) |=> p_vld)
    else $error("sine/cosine result lost");

endmodule

FILE: verif/field_relative_gimbal_angles_test.sv
// Testbench for the field-relative gimbal angle block: directed and random samples checked against a built-in predictor.
`timescale 1ns / 1ps

module field_relative_gimbal_angles_test;

  localparam int STEPS      = 16;
  localparam int USED_STEPS = (STEPS < 24) ? STEPS : 24;
  localparam int LATENCY    = 3 * USED_STEPS + 6;
  localparam int WATCHDOG   = 20000;
  localparam int N_RANDOM   = 1030;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  fgra_pkg::sample_t   sample = '0;
  logic                angles_valid;
  logic                angles_stall = 1'b1;
  fgra_pkg::angles_t   angles;
  logic                cfg_write = 1'b0;
  logic [1:0]          cfg_index = fgra_pkg::REG_YAW_OFFSET;
  logic [15:0]         cfg_data = '0;

  field_relative_gimbal_angles #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .angles_valid(angles_valid), .angles_stall(angles_stall), .angles(angles),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of the offset registers
  logic signed [15:0] yaw_trim = '0;
  logic signed [15:0] pitch_trim = '0;

  fgra_pkg::sample_t pending_samples[$];
  fgra_pkg::angles_t expected_angles[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      stimulus_done = 1'b0;
  bit      calm = 1'b0;      // no random idling on either side
  bit      hold_off = 1'b0;  // receiver back-pressure burst request
  bit      sample_taken = 1'b0;  // transaction accepted at the last rising edge

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int atan_step(int i);
    int t[24] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                  10430, 5215, 2608, 1304, 652, 326, 163, 81,
                  41, 20, 10, 5, 3, 1, 1, 0};
    return t[i];
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Rotation CORDIC; returns {sin, cos} in Q1.15
  function automatic void rotate_unit(input int ang, output longint s, output longint c);
    bit     flip;
    longint x, y, z, dx, dy;
    flip = 1'b0;
    x = 19898;
    y = 0;
    if (ang > 16384) begin
      ang -= 32768;
      flip = 1'b1;
    end else if (ang < -16384) begin
      ang += 32768;
      flip = 1'b1;
    end
    z = longint'(ang) * 256;
    for (int i = 0; i < USED_STEPS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp(x, -32768, 32767);
    s = clamp(y, -32768, 32767);
  endfunction

  // Vectoring CORDIC: drive y to zero, hand back final x and angle
  function automatic void vector_unit(input longint x, input longint y, output longint xo,
                                      output longint zo);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < USED_STEPS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    xo = x;
    zo = z;
  endfunction

  function automatic fgra_pkg::angles_t field_angles(fgra_pkg::sample_t s);
    fgra_pkg::angles_t r;
    longint sgy, cgy, scp, ccp, scr, ccr, num, p1, p2, root, z, xo;
    longint tilt;
    rotate_unit(int'(s.gimbal_yaw), sgy, cgy);
    rotate_unit(int'(s.chassis_pitch), scp, ccp);
    rotate_unit(int'(s.chassis_roll), scr, ccr);
    num = shr(cgy * scp + sgy * scr, 15);
    p1 = shr(sgy * ccr, 15);
    p2 = shr(cgy * ccp, 15);
    if (p1 < 0) p1 = -p1;
    if (p2 < 0) p2 = -p2;
    vector_unit(p2, p1, xo, z);
    root = shr(xo * 19898, 15);
    // both atan2 operands zero give a level tilt
    if (root == 0 && num == 0) begin
      tilt = 0;
    end else begin
      vector_unit(root, num, xo, z);
      tilt = clamp(shr(z + 128, 8), -16384, 16384);
    end
    r.field_yaw = 16'(s.gimbal_yaw + s.chassis_yaw - yaw_trim);
    r.field_pitch = 16'(longint'(s.gimbal_pitch) + tilt - longint'(pitch_trim));
    r.tilt_along_heading = 16'(tilt);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    error_count++;
  endtask

  // Driver: hold a transaction until it is taken, then offer the next pending sample
  always @(negedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_taken) begin
        // hold the stalled transaction
      end else if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
        sample_valid <= 1'b1;
        sample <= pending_samples[0];
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: random idling, or a long counted hold-off
  int hold_count = 0;
  always @(negedge clk) begin
    if (rst) begin
      angles_stall <= 1'b1;
    end else if (hold_off && hold_count < 300) begin
      hold_count <= hold_count + 1;
      angles_stall <= 1'b1;
    end else begin
      angles_stall <= !calm && ($urandom_range(99) < 15);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    fgra_pkg::angles_t want;
    sample_taken = 1'b0;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        sample_taken = 1'b1;
        expected_angles.push_back(field_angles(sample));
        void'(pending_samples.pop_front());
      end
      if (angles_valid && !angles_stall) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected result", angles.field_yaw, 16'h0000);
        end else begin
          want = expected_angles.pop_front();
          if (angles.field_yaw !== want.field_yaw)
            report_mismatch("field_yaw", angles.field_yaw, want.field_yaw);
          if (angles.field_pitch !== want.field_pitch)
            report_mismatch("field_pitch", angles.field_pitch, want.field_pitch);
          if (angles.tilt_along_heading !== want.tilt_along_heading)
            report_mismatch("tilt", angles.tilt_along_heading, want.tilt_along_heading);
        end
      end
    end
  end

  // Watchdog: count cycles without any transaction
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (angles_valid && !angles_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG && !stimulus_done) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input fgra_pkg::reg_index_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == fgra_pkg::REG_YAW_OFFSET) yaw_trim = value;
    else pitch_trim = value;
  endtask

  task automatic drain;
    while (pending_samples.size() > 0 || expected_angles.size() > 0) @(negedge clk);
  endtask

  function automatic logic [15:0] any_angle();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000 + 16'($urandom_range(4) - 2);
      3: return 16'hc000 + 16'($urandom_range(4) - 2);
      4: return 16'($urandom_range(8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic fgra_pkg::sample_t random_sample();
    fgra_pkg::sample_t s;
    s.gimbal_yaw = any_angle();
    s.gimbal_pitch = any_angle();
    s.chassis_yaw = any_angle();
    // mostly small chassis tilt as on a real robot, sometimes anything
    s.chassis_pitch = ($urandom_range(1)) ? 16'($urandom_range(4000) - 2000) : any_angle();
    s.chassis_roll = ($urandom_range(1)) ? 16'($urandom_range(4000) - 2000) : any_angle();
    return s;
  endfunction

  function automatic fgra_pkg::sample_t make_sample(int gy, int gp, int cy, int cp, int cr);
    fgra_pkg::sample_t s;
    s.gimbal_yaw = 16'(gy);
    s.gimbal_pitch = 16'(gp);
    s.chassis_yaw = 16'(cy);
    s.chassis_pitch = 16'(cp);
    s.chassis_roll = 16'(cr);
    return s;
  endfunction

  initial begin
    logic [15:0] yaw_settings[4] = '{16'h8000, 16'h7fff, 16'h1234, 16'hedcb};
    logic [15:0] pitch_settings[4] = '{16'h7fff, 16'h8000, 16'hfff0, 16'h0400};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, level tilt, quadrant folds and wrapping sums
    pending_samples.push_back(make_sample(0, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(32767, 32767, 32767, 32767, 32767));
    pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, -32768));
    pending_samples.push_back(make_sample(16384, 0, 0, 16384, 16384));
    pending_samples.push_back(make_sample(-16384, 0, 0, -16384, -16384));
    pending_samples.push_back(make_sample(0, 0, 0, 16384, 0));
    pending_samples.push_back(make_sample(16384, 0, 0, 0, 16384));
    pending_samples.push_back(make_sample(0, 0, 0, 16383, 16383));
    pending_samples.push_back(make_sample(16385, 100, 0, -16385, 16385));
    pending_samples.push_back(make_sample(8192, 32000, 32000, 8192, -8192));
    pending_samples.push_back(make_sample(-8192, -32000, -32000, -30000, 30000));
    pending_samples.push_back(make_sample(100, 32767, 1, 3000, -2000));
    pending_samples.push_back(make_sample(-1, -1, -1, -1, -1));
    pending_samples.push_back(make_sample(21845, 0, 21845, 16384, -16384));
    drain();
    repeat (LATENCY) @(negedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(fgra_pkg::REG_YAW_OFFSET, yaw_settings[phase]);
      write_reg(fgra_pkg::REG_PITCH_OFFSET, pitch_settings[phase]);
      calm = (phase == 1);
      if (phase == 2) begin
        // fill the pipeline while the receiver holds off
        hold_off = 1'b1;
        calm = 1'b1;
      end
      for (int n = 0; n < N_RANDOM / 4; n++) pending_samples.push_back(random_sample());
      drain();
      hold_off = 1'b0;
      calm = 1'b0;
      repeat (LATENCY) @(negedge clk);
    end

    stimulus_done = 1'b1;
    fork
      repeat (LATENCY + 20) @(negedge clk);
    join
    if (error_count == 0 && expected_angles.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Overall limit on waiting for the run to finish
  initial begin
    #(64'd20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
